/* hw/rtl/ncsi_pkg.sv */
// ncsi_pkg: widths, word types and constants for the natural cubic spline interpolator
// used by natural_cubic_spline_interp; no dependencies

package ncsi_pkg;

  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;

  // internal widths
  localparam int A_W     = SAMPLE_W + 2;           // second differences
  localparam int PQ_W    = SAMPLE_W + 7;           // 24a-6b, 24b-6a
  localparam int FG_W    = 2 * FRAC_W - 1;         // f*g
  localparam int LIN_W   = SAMPLE_W + FRAC_W + 1;  // y2*f + y1*g
  localparam int UF_W    = FRAC_W + 2;             // u+f, u+g
  localparam int M_W     = PQ_W + UF_W;            // curvature terms
  localparam int L90_W   = LIN_W + 7;              // 90*lin + rounding
  localparam int CLO_W   = 29;                     // low split of curvature sum
  localparam int CHI_W   = M_W - CLO_W;
  localparam int PL_W    = CLO_W + FG_W;
  localparam int PH_W    = CHI_W + FG_W + 1;
  localparam int PROD_W  = M_W + FG_W;
  localparam int N_W     = L90_W + 2 * FRAC_W + 2;
  localparam int X_W     = N_W - 3 * FRAC_W;
  localparam int Z_W     = SAMPLE_W + 7;
  localparam int DIV_SH  = Z_W - SAMPLE_W;
  localparam int RCP_W   = SAMPLE_W + 1;
  localparam int MUL_W   = SAMPLE_W + RCP_W;
  localparam int REM_W   = 9;
  localparam int STAGES  = 11;

  // floor(2^(DIV_SH+SAMPLE_W)/90), an underestimate of the reciprocal
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'((64'd1 << (DIV_SH + SAMPLE_W)) / 64'd90);

  localparam logic signed [X_W-1:0] ZOFS = X_W'(64'd90 << (SAMPLE_W - 1));
  localparam logic signed [X_W-1:0] ZTOP = X_W'((64'd180 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic signed [L90_W-1:0] RND_OFS = L90_W'(64'd45 << FRAC_W);

  localparam logic [REM_W-1:0] DIV1 = REM_W'(90);
  localparam logic [REM_W-1:0] DIV2 = REM_W'(180);
  localparam logic [REM_W-1:0] DIV3 = REM_W'(270);

  localparam logic [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_prev;
    logic signed [SAMPLE_W-1:0] sample_start;
    logic signed [SAMPLE_W-1:0] sample_end;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic        [FRAC_W-1:0]   frac;
  } smp_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       saturated;
  } res_t;

endpackage

/* hw/rtl/natural_cubic_spline_interp.sv */
// natural_cubic_spline_interp: four-point natural cubic spline evaluator, 11-stage pipeline
// depends on ncsi_pkg
//
// Usage: a sample word (four Q16.16 samples and a Q0.16 fraction) is taken on the smp
// channel when smp_valid and smp_ready are both high; the interpolated Q16.16 value
// and a saturation flag leave on the res channel when res_valid and res_ready are high.
// A word taken on smp passes through the eleven register stages (curvature products,
// a split 57x31 multiply, the final 90-divide done as a 32x33 reciprocal multiply with
// remainder correction) before it is presented on res. Throughput: one word per cycle
// while res_ready is high; a stalled receiver holds the flow as described below.
// Each stage moves on its own when it is empty or its successor moves, so a stalled
// receiver fills empty stages first; smp_ready drops only once every stage holds a
// word. Nothing is lost or repeated under stalls.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
// Results come out in the order the words were taken.

module natural_cubic_spline_interp
  import ncsi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic smp_valid,
  output logic smp_ready,
  input  smp_t smp,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   en;

  always_comb begin
    en[STAGES] = res_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign smp_ready = en[0];
  assign res_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= smp_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: second differences, f*g, linear products
  logic signed [SAMPLE_W-1:0] y0, y1, y2, y3;
  logic        [FRAC_W:0]     g_next;
  logic signed [A_W-1:0]      a1, b1, a1_next, b1_next;
  logic        [FG_W-1:0]     fg1, fg1_next;
  logic        [FRAC_W-1:0]   f1;
  logic        [FRAC_W:0]     g1;
  logic signed [LIN_W-1:0]    ly2_1, ly1_1, ly2_next, ly1_next;

  always_comb begin
    y0 = smp.sample_prev;
    y1 = smp.sample_start;
    y2 = smp.sample_end;
    y3 = smp.sample_next;
    g_next   = (FRAC_W+1)'(1) << FRAC_W;
    g_next   = g_next - (FRAC_W+1)'(smp.frac);
    a1_next  = A_W'(y2) - (A_W'(y1) <<< 1) + A_W'(y0);
    b1_next  = A_W'(y3) - (A_W'(y2) <<< 1) + A_W'(y1);
    fg1_next = FG_W'((2*FRAC_W+2)'(smp.frac) * (2*FRAC_W+2)'(g_next));
    ly2_next = LIN_W'(y2) * LIN_W'($signed({1'b0, smp.frac}));
    ly1_next = LIN_W'(y1) * LIN_W'($signed({1'b0, g_next}));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1    <= a1_next;
      b1    <= b1_next;
      fg1   <= fg1_next;
      f1    <= smp.frac;
      g1    <= g_next;
      ly2_1 <= ly2_next;
      ly1_1 <= ly1_next;
    end
  end

  // stage 2: scaled second derivatives, linear sum, u+f and u+g
  logic signed [PQ_W-1:0]  p2, q2, p2_next, q2_next;
  logic signed [LIN_W-1:0] lin2;
  logic        [UF_W-1:0]  uf2, ug2;
  logic        [FG_W-1:0]  fg2;

  always_comb begin
    p2_next = (PQ_W'(a1) <<< 4) + (PQ_W'(a1) <<< 3) - (PQ_W'(b1) <<< 2) - (PQ_W'(b1) <<< 1);
    q2_next = (PQ_W'(b1) <<< 4) + (PQ_W'(b1) <<< 3) - (PQ_W'(a1) <<< 2) - (PQ_W'(a1) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2   <= p2_next;
      q2   <= q2_next;
      lin2 <= ly2_1 + ly1_1;
      uf2  <= (UF_W'(1) << FRAC_W) + UF_W'(f1);
      ug2  <= (UF_W'(1) << FRAC_W) + UF_W'(g1);
      fg2  <= fg1;
    end
  end

  // stage 3: curvature products
  logic signed [M_W-1:0]   mq3, mp3;
  logic signed [LIN_W-1:0] lin3;
  logic        [FG_W-1:0]  fg3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mq3  <= M_W'(q2) * M_W'($signed({1'b0, uf2}));
      mp3  <= M_W'(p2) * M_W'($signed({1'b0, ug2}));
      lin3 <= lin2;
      fg3  <= fg2;
    end
  end

  // stage 4: curvature sum, 90*lin plus rounding offset
  logic signed [M_W-1:0]   c4;
  logic signed [L90_W-1:0] lin4, lin4_next, lx;
  logic        [FG_W-1:0]  fg4;

  always_comb begin
    lx        = L90_W'(lin3);
    lin4_next = (lx <<< 6) + (lx <<< 4) + (lx <<< 3) + (lx <<< 1) + RND_OFS;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      c4   <= mq3 + mp3;
      lin4 <= lin4_next;
      fg4  <= fg3;
    end
  end

  // stage 5: split multiply of curvature sum by f*g
  logic        [PL_W-1:0]  pl5;
  logic signed [PH_W-1:0]  ph5;
  logic signed [CHI_W-1:0] chi;
  logic signed [L90_W-1:0] lin5;

  assign chi = c4[M_W-1:CLO_W];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pl5  <= PL_W'(c4[CLO_W-1:0]) * PL_W'(fg4);
      ph5  <= PH_W'(chi) * PH_W'($signed({1'b0, fg4}));
      lin5 <= lin4;
    end
  end

  // stage 6: recombine partial products
  logic signed [PROD_W-1:0] prod6;
  logic signed [L90_W-1:0]  lin6;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      prod6 <= (PROD_W'(ph5) <<< CLO_W) + $signed(PROD_W'(pl5));
      lin6  <= lin5;
    end
  end

  // stage 7: numerator and floor shift by u^3
  logic signed [N_W-1:0] n7_next;
  logic signed [X_W-1:0] x7;

  assign n7_next = (N_W'(lin6) <<< (2 * FRAC_W)) - N_W'(prod6);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      x7 <= n7_next[N_W-1:3*FRAC_W];
    end
  end

  // stage 8: clamp and offset to a nonnegative dividend
  logic signed [X_W-1:0] zf;
  logic                  lo8, hi8;
  logic        [Z_W-1:0] z8, z8_next;
  logic                  sat8, neg8;

  always_comb begin
    zf  = x7 + ZOFS;
    lo8 = zf[X_W-1];
    hi8 = ~lo8 && (zf > ZTOP);
    if (lo8) begin
      z8_next = '0;
    end else if (hi8) begin
      z8_next = ZTOP[Z_W-1:0];
    end else begin
      z8_next = zf[Z_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      z8   <= z8_next;
      sat8 <= lo8 | hi8;
      neg8 <= lo8;
    end
  end

  // stage 9: quotient estimate by reciprocal
  logic [MUL_W-1:0]    mul9;
  logic [SAMPLE_W-1:0] qe9;
  logic [Z_W-1:0]      z9;
  logic                sat9, neg9;

  assign mul9 = MUL_W'(z8[Z_W-1:DIV_SH]) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      qe9  <= mul9[MUL_W-2:SAMPLE_W];
      z9   <= z8;
      sat9 <= sat8;
      neg9 <= neg8;
    end
  end

  // stage 10: remainder of the estimate
  logic [Z_W-1:0]      qx, r10_next;
  logic [REM_W-1:0]    r10;
  logic [SAMPLE_W-1:0] qe10;
  logic                sat10, neg10;

  always_comb begin
    qx       = Z_W'(qe9);
    r10_next = z9 - ((qx << 6) + (qx << 4) + (qx << 3) + (qx << 1));
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      r10   <= r10_next[REM_W-1:0];
      qe10  <= qe9;
      sat10 <= sat9;
      neg10 <= neg9;
    end
  end

  // stage 11: quotient correction and output word
  logic [1:0]          fix;
  logic [SAMPLE_W-1:0] qf;
  res_t                res_next;

  always_comb begin
    fix = 2'(r10 >= DIV1) + 2'(r10 >= DIV2) + 2'(r10 >= DIV3);
    qf  = qe10 + SAMPLE_W'(fix);
    res_next.saturated = sat10;
    if (sat10) begin
      res_next.value = neg10 ? SMIN : SMAX;
    end else begin
      res_next.value = qf ^ SMIN;
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      res <= res_next;
    end
  end

endmodule
